### src/cdbg_pkg.sv
// ============================================================================
// cdbg_pkg: shared types and constants
// Field widths, register indexes, event codes and the voltage threshold table
// of the charger detect and battery gauge block.
// ============================================================================
package cdbg_pkg;

    localparam int MV_W            = 12;
    localparam int CNT_W           = 8;
    localparam int PCT_W           = 7;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int TABLE_SIZE      = 32;
    localparam int LEVEL_COUNT_DEF = 20;

    localparam logic [CNT_W-1:0] CNT_MAX  = 8'd255;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [7:0]       PCT_STEP = 8'd5;

    // Register reset values
    localparam logic [CFG_W-1:0] UNPLUG_RST = 8'd5;
    localparam logic [CFG_W-1:0] SEEN_RST   = 8'd5;
    localparam logic [CFG_W-1:0] COMMIT_RST = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNPLUG = 2'd0,
        CFG_SEEN   = 2'd1,
        CFG_COMMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_DETECT = 1'b0,
        CMD_GAUGE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_UNPLUGGED = 2'd1,
        EV_PLUG_SEEN = 2'd2,
        EV_PLUGGED   = 2'd3
    } event_t;

    // Ascending thresholds in mV; entries past the defined ones are unreachable
    localparam logic [15:0] LEVEL_MV [TABLE_SIZE] = '{
        16'd2610, 16'd2746, 16'd2784, 16'd2824, 16'd2834, 16'd2854, 16'd2871, 16'd2885,
        16'd2901, 16'd2917, 16'd2935, 16'd2957, 16'd2985, 16'd3019, 16'd3057, 16'd3097,
        16'd3142, 16'd3186, 16'd3234, 16'd3288, 16'd3332, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
    };

    typedef struct packed {
        logic [CFG_W-1:0] unplug_ticks;
        logic [CFG_W-1:0] plug_seen_ticks;
        logic [CFG_W-1:0] plug_commit_ticks;
    } cdbg_cfg_t;

    typedef struct packed {
        logic             mode;
        logic [CNT_W-1:0] count;
        logic [PCT_W-1:0] shown;
    } cdbg_state_t;

    typedef struct packed {
        logic             charger_on;
        event_t           event_res;
        logic [PCT_W-1:0] battery_percent;
    } cdbg_res_t;

endpackage

### src/cdbg_if.sv
// ============================================================================
// cdbg_if: request and result channels
// Valid/ready channels carrying one request item and one result item.
// ============================================================================
interface cdbg_req_if import cdbg_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            command;
    logic            charger_pin;
    logic [MV_W-1:0] battery_mv;

    modport source (output valid, command, charger_pin, battery_mv, input ready);
    modport sink   (input valid, command, charger_pin, battery_mv, output ready);
endinterface

interface cdbg_rsp_if import cdbg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             charger_on;
    logic [1:0]       event_res;
    logic [PCT_W-1:0] battery_percent;

    modport source (output valid, charger_on, event_res, battery_percent, input ready);
    modport sink   (input valid, charger_on, event_res, battery_percent, output ready);
endinterface

### src/charger_detect_battery_gauge.sv
// ============================================================================
// charger_detect_battery_gauge: charger detect and battery fuel gauge
// Debounced charger presence detection and smoothed battery percent display.
// ============================================================================
// Usage:
//   req carries one request per handshake: a detect tick (command 0) samples
//   charger_pin, a gauge update (command 1) maps battery_mv to a percent.
//   rsp returns exactly one result per request, in order: charger mode,
//   detect event and shown percent after that request.
//   cfg_we/cfg_index/cfg_data write the three tick thresholds; write only
//   while no request is in flight.
// Timing:
//   A request is captured in an input register; its result is computed from it
//   and captured in the output register once that register is free.
//   One request per cycle sustained while rsp is ready; the threshold compare
//   and state update are combinational between the two registers.
// Reset:
//   Charger mode is set to charging, the debounce count and shown percent
//   clear, registers load 5/5/10, both channels come up empty.
// Stalls:
//   While rsp is held off, the input register still takes one more request;
//   req.ready drops once both registers are full.
// ============================================================================
module charger_detect_battery_gauge import cdbg_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cdbg_req_if.sink             req,
    cdbg_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cdbg_cfg_t        cfg;
    cdbg_state_t      state_reg;
    cdbg_state_t      state_next;
    cdbg_res_t        res;
    logic [PCT_W-1:0] level_pct;

    logic             in_vld_reg;
    logic             in_vld_next;
    logic             in_cmd_reg;
    logic             in_pin_reg;
    logic [MV_W-1:0]  in_mv_reg;

    logic             out_vld_reg;
    logic             out_vld_next;
    cdbg_res_t        out_res_reg;

    logic             req_fire;
    logic             out_free;
    logic             move;

    cdbg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cdbg_level #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_level (
        .mv        (in_mv_reg),
        .level_pct (level_pct)
    );

    cdbg_step u_step (
        .cfg         (cfg),
        .state       (state_reg),
        .command     (in_cmd_reg),
        .charger_pin (in_pin_reg),
        .level_pct   (level_pct),
        .state_next  (state_next),
        .res         (res)
    );

    assign out_free  = !out_vld_reg || rsp.ready;
    assign move      = in_vld_reg && out_free;
    assign req.ready = !in_vld_reg || out_free;
    assign req_fire  = req.valid && req.ready;

    assign in_vld_next  = req_fire ? 1'b1 : (move ? 1'b0 : in_vld_reg);
    assign out_vld_next = move ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            state_reg.mode  <= 1'b1;
            state_reg.count <= '0;
            state_reg.shown <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (move)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            in_cmd_reg <= req.command;
            in_pin_reg <= req.charger_pin;
            in_mv_reg  <= req.battery_mv;
        end
        if (move)
            out_res_reg <= res;
    end

    assign rsp.valid           = out_vld_reg;
    assign rsp.charger_on      = out_res_reg.charger_on;
    assign rsp.event_res       = out_res_reg.event_res;
    assign rsp.battery_percent = out_res_reg.battery_percent;

endmodule

### src/cdbg_cfg_regs.sv
// ============================================================================
// cdbg_cfg_regs: configuration registers
// Holds the three debounce tick thresholds, written through a plain port.
// ============================================================================
module cdbg_cfg_regs import cdbg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cdbg_cfg_t            cfg
);

    cdbg_cfg_t cfg_reg;
    cdbg_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_UNPLUG: cfg_next.unplug_ticks      = cfg_data;
                CFG_SEEN:   cfg_next.plug_seen_ticks   = cfg_data;
                CFG_COMMIT: cfg_next.plug_commit_ticks = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unplug_ticks      <= UNPLUG_RST;
            cfg_reg.plug_seen_ticks   <= SEEN_RST;
            cfg_reg.plug_commit_ticks <= COMMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/cdbg_level.sv
// ============================================================================
// cdbg_level: voltage to percent map
// Counts the thresholds a voltage reaches and scales to percent in steps of 5.
// ============================================================================
module cdbg_level import cdbg_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
)
(
    input  logic [MV_W-1:0]  mv,
    output logic [PCT_W-1:0] level_pct
);

    localparam int LVL_W = $clog2(LEVEL_COUNT + 1);

    logic [LVL_W-1:0] level;
    logic [7:0]       pct_raw;

    // Thresholds ascend, so the count of reached ones equals the first miss
    always_comb
    begin
        level = '0;
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            if ({4'b0, mv} >= LEVEL_MV[i])
                level = level + 1'b1;
        end
    end

    assign pct_raw   = 8'(level) * PCT_STEP;
    assign level_pct = (pct_raw > {1'b0, PCT_MAX}) ? PCT_MAX : pct_raw[PCT_W-1:0];

endmodule

### src/cdbg_step.sv
// ============================================================================
// cdbg_step: per-item state update
// Debounces the charger pin on detect ticks and smooths the shown percent on
// gauge updates; gives the next state and the result of one item.
// ============================================================================
module cdbg_step import cdbg_pkg::*;
(
    input  cdbg_cfg_t        cfg,
    input  cdbg_state_t      state,
    input  logic             command,
    input  logic             charger_pin,
    input  logic [PCT_W-1:0] level_pct,
    output cdbg_state_t      state_next,
    output cdbg_res_t        res
);

    logic [CNT_W-1:0] count_inc;
    event_t           ev;

    assign count_inc = (state.count == CNT_MAX) ? CNT_MAX : state.count + 1'b1;

    always_comb
    begin
        state_next = state;
        ev         = EV_NONE;
        case (cmd_t'(command))
            CMD_DETECT:
            begin
                state_next.count = count_inc;
                if (state.mode)
                begin
                    if (!charger_pin)
                    begin
                        if (count_inc == cfg.unplug_ticks)
                        begin
                            state_next.mode = 1'b0;
                            ev              = EV_UNPLUGGED;
                        end
                    end
                    else
                    begin
                        state_next.count = '0;
                    end
                end
                else
                begin
                    if (charger_pin)
                    begin
                        // seen wins over commit when both match
                        if (count_inc == cfg.plug_seen_ticks)
                        begin
                            ev = EV_PLUG_SEEN;
                        end
                        else if (count_inc == cfg.plug_commit_ticks)
                        begin
                            state_next.mode = 1'b1;
                            ev              = EV_PLUGGED;
                        end
                    end
                    else
                    begin
                        state_next.count = '0;
                    end
                end
            end
            CMD_GAUGE:
            begin
                if (state.shown == '0)
                    state_next.shown = level_pct;
                else if (state.shown < level_pct)
                begin
                    if (state.mode)
                        state_next.shown = state.shown + 1'b1;
                end
                else if (state.shown > level_pct)
                begin
                    if (!state.mode)
                        state_next.shown = state.shown - 1'b1;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    assign res.charger_on      = state_next.mode;
    assign res.event_res       = ev;
    assign res.battery_percent = state_next.shown;

endmodule

### sim/tb_charger_detect_battery_gauge.sv
// ============================================================================
// tb_charger_detect_battery_gauge: self-checking bench for the charger
// detect and battery gauge block
// Feeds detect ticks and gauge updates over the request channel and predicts
// the charger mode, the detect event and the shown percent of every result.
// Each result is checked in order against the prediction. Threshold
// registers are rewritten between phases while the block is drained. Both
// channels idle at random, and the result side is stalled long enough to
// back up the request side.
// ============================================================================
module tb_charger_detect_battery_gauge;
    import cdbg_pkg::*;

    localparam int MAX_GAP        = 13;
    localparam int LONG_HOLD      = 48;
    localparam int WATCHDOG_LIMIT = 600;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        cmd_t            command;
        logic            pin;
        logic [MV_W-1:0] mv;
    } charger_req_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    cdbg_req_if req_bus();
    cdbg_rsp_if rsp_bus();

    charger_detect_battery_gauge dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted block state and register copy
    logic [CFG_W-1:0] unplug_ticks = UNPLUG_RST;
    logic [CFG_W-1:0] seen_ticks   = SEEN_RST;
    logic [CFG_W-1:0] commit_ticks = COMMIT_RST;
    logic             chg_mode     = 1'b1;
    logic [CNT_W-1:0] dbc_count    = '0;
    logic [PCT_W-1:0] shown_pct    = '0;

    charger_req_t pending_requests[$];
    cdbg_res_t    expected_results[$];
    charger_req_t cur_req;
    cdbg_res_t    want_res;

    int  mismatches    = 0;
    int  results_seen  = 0;
    int  src_gap       = 0;
    int  snk_wait      = 0;
    int  long_hold_req = 0;
    int  long_hold_ack = 0;
    int  long_hold_left = 0;
    int  idle_cycles   = 0;
    bit  src_calm      = 0;
    bit  snk_calm      = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [PCT_W-1:0] mv_to_level(logic [MV_W-1:0] mv);
        int n;
        n = 0;
        while (n < LEVEL_COUNT_DEF && n < TABLE_SIZE && {4'b0, mv} >= LEVEL_MV[n])
            n++;
        if (n * int'(PCT_STEP) > int'(PCT_MAX))
            return PCT_MAX;
        return PCT_W'(n * int'(PCT_STEP));
    endfunction

    // Advances the predicted state by one request and returns its result
    function automatic cdbg_res_t charger_gauge_step(charger_req_t r);
        cdbg_res_t        res;
        event_t           ev;
        logic [PCT_W-1:0] lvl;
        ev = EV_NONE;
        if (r.command == CMD_DETECT)
        begin
            // count advances before the pin is judged
            if (dbc_count != CNT_MAX)
                dbc_count = dbc_count + 1'b1;
            if (chg_mode)
            begin
                if (!r.pin)
                begin
                    if (dbc_count == unplug_ticks)
                    begin
                        chg_mode = 1'b0;
                        ev = EV_UNPLUGGED;
                    end
                end
                else
                    dbc_count = '0;
            end
            else
            begin
                if (r.pin)
                begin
                    // seen takes priority when both thresholds are equal
                    if (dbc_count == seen_ticks)
                        ev = EV_PLUG_SEEN;
                    else if (dbc_count == commit_ticks)
                    begin
                        chg_mode = 1'b1;
                        ev = EV_PLUGGED;
                    end
                end
                else
                    dbc_count = '0;
            end
        end
        else
        begin
            lvl = mv_to_level(r.mv);
            if (shown_pct == '0)
                shown_pct = lvl;
            else if (shown_pct < lvl)
            begin
                if (chg_mode)
                    shown_pct = shown_pct + 1'b1;
            end
            else if (shown_pct > lvl)
            begin
                if (!chg_mode)
                    shown_pct = shown_pct - 1'b1;
            end
        end
        res.charger_on      = chg_mode;
        res.event_res       = ev;
        res.battery_percent = shown_pct;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("ERROR result %0d: %s", results_seen, what);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid       <= 1'b0;
            req_bus.command     <= CMD_DETECT;
            req_bus.charger_pin <= 1'b0;
            req_bus.battery_mv  <= '0;
            src_gap = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                expected_results.push_back(charger_gauge_step(cur_req));
            if (!req_bus.valid || req_bus.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    cur_req = pending_requests.pop_front();
                    req_bus.valid       <= 1'b1;
                    req_bus.command     <= cur_req.command;
                    req_bus.charger_pin <= cur_req.pin;
                    req_bus.battery_mv  <= cur_req.mv;
                    src_gap = src_calm ? 0 : int'($urandom_range(0, MAX_GAP));
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor and ready control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            snk_wait = 0;
            long_hold_left = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want_res = expected_results.pop_front();
                    if (rsp_bus.charger_on !== want_res.charger_on)
                        report_mismatch($sformatf("charger_on %b, want %b",
                            rsp_bus.charger_on, want_res.charger_on));
                    if (rsp_bus.event_res !== want_res.event_res)
                        report_mismatch($sformatf("event_res %0d, want %0d",
                            rsp_bus.event_res, want_res.event_res));
                    if (rsp_bus.battery_percent !== want_res.battery_percent)
                        report_mismatch($sformatf("battery_percent %0d, want %0d",
                            rsp_bus.battery_percent, want_res.battery_percent));
                end
                results_seen++;
                snk_wait = snk_calm ? 0 : int'($urandom_range(0, MAX_GAP));
            end
            if (long_hold_ack != long_hold_req)
            begin
                long_hold_ack = long_hold_req;
                long_hold_left = LONG_HOLD;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (snk_wait > 0)
            begin
                snk_wait--;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("charger_detect_battery_gauge: mismatch");
            $finish;
        end
    end

    function automatic logic [MV_W-1:0] random_mv();
        int t;
        case ($urandom_range(0, 4))
            0, 1:
                return MV_W'($urandom_range(0, 4095));
            2:
                return $urandom_range(0, 1) ? '1 : '0;
            default:
            begin
                // land on or next to a threshold
                t = int'(LEVEL_MV[$urandom_range(0, LEVEL_COUNT_DEF)])
                    + int'($urandom_range(0, 2)) - 1;
                return MV_W'(t);
            end
        endcase
    endfunction

    task automatic push_tick(logic pin);
        charger_req_t r;
        r.command = CMD_DETECT;
        r.pin     = pin;
        r.mv      = MV_W'($urandom_range(0, 4095));
        pending_requests.push_back(r);
    endtask

    task automatic push_gauge(logic [MV_W-1:0] mv);
        charger_req_t r;
        r.command = CMD_GAUGE;
        r.pin     = 1'($urandom_range(0, 1));
        r.mv      = mv;
        pending_requests.push_back(r);
    endtask

    // Runs of one pin level sized around the thresholds, plus loose noise
    task automatic queue_random(int count);
        int   left;
        int   run;
        logic pin_level;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pin_level = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0:       run = int'(unplug_ticks);
                    1:       run = int'(seen_ticks);
                    2:       run = int'(commit_ticks);
                    default: run = int'($urandom_range(1, 16));
                endcase
                run = run + int'($urandom_range(0, 3)) - 1;
                if (run < 1)
                    run = 1;
                for (int k = 0; k < run; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        push_gauge(random_mv());
                    push_tick(pin_level);
                end
                left -= run;
            end
            else
            begin
                if ($urandom_range(0, 1))
                    push_gauge(random_mv());
                else
                    push_tick(1'($urandom_range(0, 1)));
                left--;
            end
        end
    endtask

    task automatic queue_run(logic pin, int run);
        for (int k = 0; k < run; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                push_gauge(random_mv());
            push_tick(pin);
        end
    endtask

    // Sender pause: waits until nothing is queued and nothing is in flight
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_UNPLUG: unplug_ticks = val;
            CFG_SEEN:   seen_ticks   = val;
            CFG_COMMIT: commit_ticks = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic start_phase(logic [CFG_W-1:0] unplug, logic [CFG_W-1:0] seen,
                               logic [CFG_W-1:0] commit, bit calm_src, bit calm_snk,
                               bit long_hold);
        wait_drained();
        write_reg(CFG_UNPLUG, unplug);
        write_reg(CFG_SEEN, seen);
        write_reg(CFG_COMMIT, commit);
        @(negedge clk);
        src_calm = calm_src;
        snk_calm = calm_snk;
        if (long_hold)
            long_hold_req++;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_UNPLUG;
        cfg_data            = '0;
        req_bus.valid       = 1'b0;
        req_bus.command     = CMD_DETECT;
        req_bus.charger_pin = 1'b0;
        req_bus.battery_mv  = '0;
        rsp_bus.ready       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: percent load, clamp, both directions, unplug, seen, commit
        push_gauge('0);
        push_gauge('1);
        push_gauge('0);
        queue_run(1'b0, 0);
        for (int k = 0; k < 5; k++)
            push_tick(1'b0);
        push_gauge(MV_W'(2609));
        push_gauge(MV_W'(3332));
        push_tick(1'b1);
        push_tick(1'b0);
        for (int k = 0; k < 10; k++)
            push_tick(1'b1);
        push_gauge(MV_W'(2610));
        push_gauge(MV_W'(3288));
        push_gauge(MV_W'(3287));

        // Thresholds all equal at 1; stall results while requests pile up
        start_phase(8'd1, 8'd1, 8'd1, 1'b1, 1'b0, 1'b1);
        queue_random(70);

        start_phase(8'd3, 8'd2, 8'd7, 1'b0, 1'b0, 1'b0);
        queue_random(70);

        // Zero unplug register: a long low run never fires and saturates
        start_phase(8'd0, 8'd4, 8'd8, 1'b0, 1'b1, 1'b0);
        queue_run(1'b1, 9);
        queue_run(1'b0, 300);

        // Top thresholds; the saturated count meets 255 on the first low tick
        start_phase(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
        queue_run(1'b0, 1);
        queue_run(1'b0, 1);
        queue_run(1'b1, 262);

        start_phase(8'd6, 8'd6, 8'd6, 1'b1, 1'b1, 1'b0);
        queue_random(70);

        start_phase(8'd2, 8'd5, 8'd9, 1'b1, 1'b0, 1'b1);
        queue_random(70);

        // Commit below seen: charging is entered before the seen count
        start_phase(8'd4, 8'd9, 8'd3, 1'b0, 1'b0, 1'b0);
        queue_random(70);

        start_phase(8'd12, 8'd1, 8'd12, 1'b0, 1'b1, 1'b0);
        queue_random(70);

        start_phase(UNPLUG_RST, SEEN_RST, COMMIT_RST, 1'b0, 1'b0, 1'b0);
        queue_random(70);

        wait_drained();
        if (mismatches == 0)
            $display("charger_detect_battery_gauge: match");
        else
            $display("charger_detect_battery_gauge: mismatch");
        $finish;
    end

endmodule
